### src/dtia_pkg.sv
// dtia_pkg: shared widths, codes and sequencer states of the draft tree block
// no dependencies; used by the channel interfaces and the top level
package dtia_pkg;

  localparam int IDX_W   = 6;
  localparam int DEPTH_W = 6;
  localparam int CNT_W   = 7;
  localparam int MASK_W  = 64;
  localparam int STAT_W  = 2;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NO_PARENT = 2'd2,
    STAT_BRANCH    = 2'd3
  } status_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_CLEAR  = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LINK,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

### src/dtia_req_if.sv
// dtia_req_if: request channel (insert or clear) with valid/ready handshake
// depends on dtia_pkg
interface dtia_req_if import dtia_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [IDX_W-1:0] parent_index;

  modport source (output valid, req_type, parent_index, input ready);
  modport sink   (input valid, req_type, parent_index, output ready);
endinterface

### src/dtia_rsp_if.sv
// dtia_rsp_if: result channel carrying status, new node data and tree counts
// depends on dtia_pkg
interface dtia_rsp_if import dtia_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [IDX_W-1:0]   node_index;
  logic [DEPTH_W-1:0] node_depth;
  logic [MASK_W-1:0]  ancestor_mask;
  logic [IDX_W-1:0]   leaf_slot;
  logic [CNT_W-1:0]   node_count;
  logic [CNT_W-1:0]   leaf_count;
  logic [DEPTH_W-1:0] depth_peak;

  modport source (output valid, status, node_index, node_depth, ancestor_mask, leaf_slot,
                  node_count, leaf_count, depth_peak, input ready);
  modport sink   (input valid, status, node_index, node_depth, ancestor_mask, leaf_slot,
                  node_count, leaf_count, depth_peak, output ready);
endinterface

### src/draft_tree_insert_ancestor_mask.sv
// draft_tree_insert_ancestor_mask: bounded draft token tree with ancestor masks
// depends on dtia_pkg, dtia_req_if, dtia_rsp_if
//
//   channel   dir  handshake               contents
//   in_req    in   valid/ready             req_type, parent_index
//   out_rsp   out  valid/ready             status, node data, counts, depth_peak
//   cfg       in   cfg_we, no back-press   start depth (6 bits)
//
// states per request: clear, tree full or missing parent go idle, done; branch limit
// goes idle, check, done; insert goes idle, check, link, done, with a leaf list scan
// before done on a first child; the scan reads one leaf list entry a cycle
// in_req.ready is high only in idle; a finished result waits in the output
// register while the next transaction is taken
// rst_n is synchronous: tree holds the root alone, start depth reads 0
module draft_tree_insert_ancestor_mask import dtia_pkg::*; #(
  parameter int MAX_NODES    = 64,
  parameter int MAX_CHILDREN = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  dtia_req_if.sink           in_req,
  dtia_rsp_if.source         out_rsp,
  input  logic               cfg_we,
  input  logic [DEPTH_W-1:0] cfg_wdata
);

  localparam int IW  = $clog2(MAX_NODES);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int CCW = $clog2(MAX_CHILDREN + 1);
  localparam int MN  = MAX_NODES;

  // node stores and leaf list
  logic [DEPTH_W-1:0] depth_mem [MN];
  logic [MN-1:0]      mask_mem  [MN];
  logic [CCW-1:0]     cc_mem    [MN];
  logic [IW-1:0]      leaf_mem  [MN];

  logic [DEPTH_W-1:0] depth_rd_r;
  logic [MN-1:0]      mask_rd_r;
  logic [CCW-1:0]     cc_rd_r;
  logic [IW-1:0]      leaf_rd_r;

  state_t             state_r, state_nxt;
  logic [IW-1:0]      parent_r, parent_nxt;
  logic [CW-1:0]      nodes_r, nodes_nxt;
  logic [CW-1:0]      leaves_r, leaves_nxt;
  logic [DEPTH_W-1:0] deepest_r, deepest_nxt;
  logic [DEPTH_W-1:0] start_r;
  logic [CCW-1:0]     root_cc_r, root_cc_nxt;
  logic               leaf0_root_r, leaf0_root_nxt;
  logic [CCW-1:0]     cc_new_r, cc_new_nxt;
  logic [IW-1:0]      scan_r, scan_nxt;

  status_t            res_status_r, res_status_nxt;
  logic [IW-1:0]      res_idx_r, res_idx_nxt;
  logic [DEPTH_W-1:0] res_depth_r, res_depth_nxt;
  logic [MN-1:0]      res_mask_r, res_mask_nxt;
  logic [IW-1:0]      res_slot_r, res_slot_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [IW-1:0]      out_idx_r, out_idx_nxt;
  logic [DEPTH_W-1:0] out_depth_r, out_depth_nxt;
  logic [MN-1:0]      out_mask_r, out_mask_nxt;
  logic [IW-1:0]      out_slot_r, out_slot_nxt;
  logic [CW-1:0]      out_nodes_r, out_nodes_nxt;
  logic [CW-1:0]      out_leaves_r, out_leaves_nxt;
  logic [DEPTH_W-1:0] out_max_r, out_max_nxt;

  // memory write ports
  logic               node_we;
  logic               cc_we;
  logic [IW-1:0]      cc_waddr;
  logic [CCW-1:0]     cc_wdata;
  logic               leaf_we;
  logic [IW-1:0]      leaf_waddr;
  logic [IW-1:0]      leaf_raddr;

  logic               in_fire;
  logic               parent_root;
  logic [CCW-1:0]     par_cc;
  logic [DEPTH_W-1:0] par_depth;
  logic [MN-1:0]      par_mask;
  logic [IW-1:0]      new_idx;
  logic [DEPTH_W-1:0] new_depth;
  logic [MN-1:0]      new_mask;
  logic [IW-1:0]      leaf_entry;

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;

  assign parent_root = (parent_r == '0);
  assign par_cc      = parent_root ? root_cc_r : cc_rd_r;
  assign par_depth   = parent_root ? '0 : depth_rd_r;
  assign par_mask    = parent_root ? MN'(1) : mask_rd_r;
  assign new_idx     = nodes_r[IW-1:0];
  assign new_depth   = DEPTH_W'(par_depth + DEPTH_W'(1));
  assign new_mask    = par_mask | (MN'(1) << new_idx);
  assign leaf_entry  = (scan_r == '0 && leaf0_root_r) ? '0 : leaf_rd_r;

  always_ff @(posedge clk) begin
    depth_rd_r <= depth_mem[in_req.parent_index[IW-1:0]];
    mask_rd_r  <= mask_mem[in_req.parent_index[IW-1:0]];
    cc_rd_r    <= cc_mem[in_req.parent_index[IW-1:0]];
    leaf_rd_r  <= leaf_mem[leaf_raddr];
    if (node_we) begin
      depth_mem[new_idx] <= new_depth;
      mask_mem[new_idx]  <= new_mask;
    end
    if (cc_we) begin
      cc_mem[cc_waddr] <= cc_wdata;
    end
    if (leaf_we) begin
      leaf_mem[leaf_waddr] <= res_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
    end else if (cfg_we) begin
      start_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      nodes_r      <= CW'(1);
      leaves_r     <= CW'(1);
      deepest_r    <= '0;
      root_cc_r    <= '0;
      leaf0_root_r <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      nodes_r      <= nodes_nxt;
      leaves_r     <= leaves_nxt;
      deepest_r    <= deepest_nxt;
      root_cc_r    <= root_cc_nxt;
      leaf0_root_r <= leaf0_root_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    parent_r     <= parent_nxt;
    cc_new_r     <= cc_new_nxt;
    scan_r       <= scan_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_depth_r  <= res_depth_nxt;
    res_mask_r   <= res_mask_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_depth_r  <= out_depth_nxt;
    out_mask_r   <= out_mask_nxt;
    out_slot_r   <= out_slot_nxt;
    out_nodes_r  <= out_nodes_nxt;
    out_leaves_r <= out_leaves_nxt;
    out_max_r    <= out_max_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    parent_nxt     = parent_r;
    nodes_nxt      = nodes_r;
    leaves_nxt     = leaves_r;
    deepest_nxt    = deepest_r;
    root_cc_nxt    = root_cc_r;
    leaf0_root_nxt = leaf0_root_r;
    cc_new_nxt     = cc_new_r;
    scan_nxt       = scan_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_depth_nxt  = res_depth_r;
    res_mask_nxt   = res_mask_r;
    res_slot_nxt   = res_slot_r;
    out_valid_nxt  = out_valid_r && !out_rsp.ready;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_depth_nxt  = out_depth_r;
    out_mask_nxt   = out_mask_r;
    out_slot_nxt   = out_slot_r;
    out_nodes_nxt  = out_nodes_r;
    out_leaves_nxt = out_leaves_r;
    out_max_nxt    = out_max_r;
    node_we        = 1'b0;
    cc_we          = 1'b0;
    cc_waddr       = new_idx;
    cc_wdata       = '0;
    leaf_we        = 1'b0;
    leaf_waddr     = scan_r;
    leaf_raddr     = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          parent_nxt     = in_req.parent_index[IW-1:0];
          res_status_nxt = STAT_OK;
          res_idx_nxt    = '0;
          res_depth_nxt  = '0;
          res_mask_nxt   = '0;
          res_slot_nxt   = '0;
          state_nxt      = ST_DONE;
          if (in_req.req_type == REQ_CLEAR) begin
            nodes_nxt      = CW'(1);
            leaves_nxt     = CW'(1);
            deepest_nxt    = start_r;
            root_cc_nxt    = '0;
            leaf0_root_nxt = 1'b1;
            res_mask_nxt   = MN'(1);
          end else if (CNT_W'(nodes_r) >= CNT_W'(MAX_NODES)) begin
            res_status_nxt = STAT_FULL;
          end else if ({1'b0, in_req.parent_index} >= CNT_W'(nodes_r)) begin
            res_status_nxt = STAT_NO_PARENT;
          end else begin
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (par_cc >= CCW'(MAX_CHILDREN)) begin
          res_status_nxt = STAT_BRANCH;
          state_nxt      = ST_DONE;
        end else begin
          node_we       = 1'b1;
          cc_we         = 1'b1;
          nodes_nxt     = CW'(nodes_r + CW'(1));
          if (new_depth > deepest_r) begin
            deepest_nxt = new_depth;
          end
          cc_new_nxt    = CCW'(par_cc + CCW'(1));
          res_idx_nxt   = new_idx;
          res_depth_nxt = new_depth;
          res_mask_nxt  = new_mask;
          state_nxt     = ST_LINK;
        end
      end
      ST_LINK: begin
        if (parent_root) begin
          root_cc_nxt = cc_new_r;
        end else begin
          cc_we    = 1'b1;
          cc_waddr = parent_r;
          cc_wdata = cc_new_r;
        end
        if (cc_new_r == CCW'(1)) begin
          leaf_raddr = '0;
          scan_nxt   = '0;
          state_nxt  = ST_SCAN;
        end else begin
          // later child goes to the end of the leaf list
          leaf_we      = 1'b1;
          leaf_waddr   = leaves_r[IW-1:0];
          res_slot_nxt = leaves_r[IW-1:0];
          leaves_nxt   = CW'(leaves_r + CW'(1));
          state_nxt    = ST_DONE;
        end
      end
      ST_SCAN: begin
        leaf_raddr = IW'(scan_r + IW'(1));
        if (leaf_entry == parent_r) begin
          // first child takes over the parent's slot
          leaf_we      = 1'b1;
          leaf_waddr   = scan_r;
          res_slot_nxt = scan_r;
          if (scan_r == '0) begin
            leaf0_root_nxt = 1'b0;
          end
          state_nxt = ST_DONE;
        end else if (CNT_W'(scan_r) + CNT_W'(1) >= CNT_W'(leaves_r)) begin
          res_slot_nxt = '0;
          state_nxt    = ST_DONE;
        end else begin
          scan_nxt = IW'(scan_r + IW'(1));
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = res_idx_r;
          out_depth_nxt  = res_depth_r;
          out_mask_nxt   = res_mask_r;
          out_slot_nxt   = res_slot_r;
          out_nodes_nxt  = nodes_r;
          out_leaves_nxt = leaves_r;
          out_max_nxt    = deepest_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.node_index    = IDX_W'(out_idx_r);
  assign out_rsp.node_depth    = out_depth_r;
  assign out_rsp.ancestor_mask = MASK_W'(out_mask_r);
  assign out_rsp.leaf_slot     = IDX_W'(out_slot_r);
  assign out_rsp.node_count    = CNT_W'(out_nodes_r);
  assign out_rsp.leaf_count    = CNT_W'(out_leaves_r);
  assign out_rsp.depth_peak    = out_max_r;

  a_node_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_r >= CW'(1) && CNT_W'(nodes_r) <= CNT_W'(MAX_NODES))
    else $error("node count out of range");

  a_leaves_le_nodes: assert property (@(posedge clk) disable iff (!rst_n)
    leaves_r >= CW'(1) && leaves_r <= nodes_r)
    else $error("leaf count exceeds node count");

  a_scan_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> CNT_W'(scan_r) < CNT_W'(leaves_r))
    else $error("leaf scan past end of list");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != STAT_OK |-> out_idx_r == '0 && out_mask_r == '0)
    else $error("rejected insert carries node data");

endmodule
